@@ hdl/dmr_pkg.sv @@
// Shared constants and helper functions for the double to minifloat converter.
package dmr_pkg;

  // Configuration register byte addresses.
  localparam logic [2:0] REG_EXP_WIDTH_ADDR  = 3'd0;
  localparam logic [2:0] REG_FRAC_WIDTH_ADDR = 3'd4;

  // Double precision field constants.
  localparam logic [10:0] DEXP_ALL_ONES = 11'h7FF;
  localparam int          DOUBLE_BIAS   = 1023;
  localparam int          DOUBLE_FRAC   = 52;

  // Widest right shift that still matters when rounding a 53-bit significand.
  localparam logic [5:0] MAX_RSHIFT = 6'd54;

  // Clamp the exponent width to the supported range.
  function automatic logic [3:0] eff_ew(input logic [3:0] raw);
    logic [3:0] e;
    e = raw;
    if (e < 4'd2) e = 4'd2;
    if (e > 4'd11) e = 4'd11;
    return e;
  endfunction

  // Clamp the fraction width to the supported range.
  function automatic logic [5:0] eff_fw(input logic [5:0] raw);
    logic [5:0] f;
    f = raw;
    if (f < 6'd1) f = 6'd1;
    if (f > 6'd52) f = 6'd52;
    return f;
  endfunction

endpackage

@@ hdl/double_to_minifloat_rne.sv @@
// Pipelined converter from IEEE double to a configurable minifloat with round to nearest even.
//
// Each word on the input stream is one IEEE 754 double; each output word is the same value
// packed right aligned as sign, exponent and fraction of a narrower float, with the overflow
// flag on out_tuser. Exponent width (2..11) and fraction width (1..52) come from the APB
// registers at 0x0 and 0x4 and may only change while the pipeline is empty. The converter
// takes one word per clock while the output is not stalled, and each word passes through
// four register stages: stage one finds the leading one, stage two
// aligns the significand with a barrel shifter, stage three rounds, and the output stage
// renormalizes and packs. A stall at the output holds all stages together, so in_tready
// follows out_tready whenever the output register is full.
module double_to_minifloat_rne (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: tdata = value_bits[63:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // Output stream: tdata = packed_bits[63:0]; tuser = overflowed[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tuser,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [3:0] exp_width_r;
  logic [5:0] frac_width_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_width_r  <= 4'd8;
      frac_width_r <= 6'd23;
    end else if (cfg_wr) begin
      if (cfg_paddr == dmr_pkg::REG_EXP_WIDTH_ADDR) exp_width_r <= cfg_pwdata[3:0];
      if (cfg_paddr == dmr_pkg::REG_FRAC_WIDTH_ADDR) frac_width_r <= cfg_pwdata[5:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      dmr_pkg::REG_EXP_WIDTH_ADDR:  cfg_prdata = {28'd0, exp_width_r};
      dmr_pkg::REG_FRAC_WIDTH_ADDR: cfg_prdata = {26'd0, frac_width_r};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  // Effective widths and the format constants derived from them.
  logic [3:0]         ew;
  logic [5:0]         fw;
  logic signed [12:0] bias;
  logic signed [12:0] emin;
  logic [11:0]        expmax;

  assign ew     = dmr_pkg::eff_ew(exp_width_r);
  assign fw     = dmr_pkg::eff_fw(frac_width_r);
  assign bias   = $signed(13'(13'd1 << (ew - 4'd1))) - 13'sd1;
  assign emin   = 13'sd1 - bias;
  assign expmax = 12'((13'd1 << ew) - 13'd1);

  // Whole pipeline advances together when the output register can move.
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Stage 1: decode, special values and leading one search.
  logic               in_sign;
  logic [10:0]        in_dexp;
  logic [51:0]        in_man;
  logic [52:0]        in_sig;
  logic [5:0]         lz_pos;
  logic signed [12:0] in_e2;
  logic [63:0]        spec_word;
  logic               in_special;
  logic [63:0]        sign_pos_in;

  assign in_sign     = in_tdata[63];
  assign in_dexp     = in_tdata[62:52];
  assign in_man      = in_tdata[51:0];
  assign in_sig      = {(in_dexp != 11'd0), in_man};
  assign in_e2       = (in_dexp != 11'd0) ?
                       ($signed({2'b00, in_dexp}) - 13'sd1023) : -13'sd1022;
  assign sign_pos_in = 64'(in_sign) << (7'(ew) + 7'(fw));
  assign in_special  = (in_dexp == dmr_pkg::DEXP_ALL_ONES) ||
                       (in_dexp == 11'd0 && in_man == 52'd0);

  always_comb begin
    lz_pos = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (in_sig[i]) lz_pos = 6'(i);
    end
  end

  always_comb begin
    if (in_dexp == dmr_pkg::DEXP_ALL_ONES) begin
      spec_word = sign_pos_in | (64'(expmax) << fw);
      if (in_man != 52'd0) begin
        spec_word = spec_word | 64'(in_man >> (6'd52 - fw)) | (64'd1 << (fw - 6'd1));
      end
    end else begin
      spec_word = sign_pos_in;
    end
  end

  logic               v1_r;
  logic               sign1_r;
  logic               spec1_r;
  logic [63:0]        sword1_r;
  logic [52:0]        sig1_r;
  logic signed [12:0] e2_1_r;
  logic signed [12:0] lead1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sign1_r  <= in_sign;
      spec1_r  <= in_special;
      sword1_r <= spec_word;
      sig1_r   <= in_sig;
      e2_1_r   <= in_e2;
      lead1_r  <= in_e2 - 13'sd52 + $signed({7'd0, lz_pos});
    end
  end

  // Stage 2: align the significand to the target ulp, keeping guard and sticky.
  logic signed [12:0] top2;
  logic signed [12:0] d2;
  logic [53:0]        q2;
  logic               g2;
  logic               s2;
  logic [5:0]         rsh;
  logic [106:0]       ext2;

  assign top2 = (lead1_r > emin) ? lead1_r : emin;
  assign d2   = top2 - $signed({7'd0, fw}) - e2_1_r + 13'sd52;

  always_comb begin
    rsh  = (d2 > 13'sd54) ? dmr_pkg::MAX_RSHIFT : d2[5:0];
    ext2 = {sig1_r, 54'd0} >> rsh;
    if (d2 <= 13'sd0) begin
      q2 = 54'(sig1_r) << 6'(-d2);
      g2 = 1'b0;
      s2 = 1'b0;
    end else begin
      q2 = {1'b0, ext2[106:54]};
      g2 = ext2[53];
      s2 = |ext2[52:0];
    end
  end

  logic               v2_r;
  logic               sign2_r;
  logic               spec2_r;
  logic [63:0]        sword2_r;
  logic [53:0]        q2_r;
  logic               g2_r;
  logic               s2_r;
  logic signed [12:0] top2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sign2_r  <= sign1_r;
      spec2_r  <= spec1_r;
      sword2_r <= sword1_r;
      q2_r     <= q2;
      g2_r     <= g2;
      s2_r     <= s2;
      top2_r   <= top2;
    end
  end

  // Stage 3: round to nearest, ties to even.
  logic               v3_r;
  logic               sign3_r;
  logic               spec3_r;
  logic [63:0]        sword3_r;
  logic [53:0]        q3_r;
  logic signed [12:0] top3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sign3_r  <= sign2_r;
      spec3_r  <= spec2_r;
      sword3_r <= sword2_r;
      q3_r     <= q2_r + 54'(g2_r && (s2_r || q2_r[0]));
      top3_r   <= top2_r;
    end
  end

  // Stage 4: renormalize after a rounding carry, check overflow and pack.
  logic [53:0]        qn;
  logic signed [12:0] xr;
  logic signed [12:0] biased;
  logic [63:0]        sign_pos4;
  logic [63:0]        pack_nxt;
  logic               ovf_nxt;

  assign sign_pos4 = 64'(sign3_r) << (7'(ew) + 7'(fw));

  always_comb begin
    qn       = q3_r;
    xr       = top3_r;
    ovf_nxt  = 1'b0;
    if (q3_r[fw + 6'd1]) begin
      qn = q3_r >> 1;
      xr = top3_r + 13'sd1;
    end
    biased = xr + bias;
    if (spec3_r) begin
      pack_nxt = sword3_r;
    end else if (qn[fw]) begin
      if (biased >= $signed({1'b0, expmax})) begin
        pack_nxt = sign_pos4 | (64'(expmax) << fw);
        ovf_nxt  = 1'b1;
      end else begin
        pack_nxt = sign_pos4 | (64'(biased[11:0]) << fw) |
                   (64'(qn) & ~(64'd1 << fw));
      end
    end else begin
      pack_nxt = sign_pos4 | 64'(qn);
    end
  end

  logic [63:0] pack_r;
  logic        ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pack_r <= pack_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pack_r;
  assign out_tuser  = ovf_r;

  // Packed word never uses bits above the sign position.
  a_no_high_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_tdata >> (7'(ew) + 7'(fw) + 7'd1)) == 64'd0))
    else $error("packed word has bits above the sign");

  // An overflowed result is infinity: zero fraction, all ones exponent.
  a_ovf_is_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser) |->
      ((out_tdata & ((64'd1 << fw) - 64'd1)) == 64'd0) &&
      (((out_tdata >> fw) & 64'(expmax)) == 64'(expmax)))
    else $error("overflow flag without infinity");

  // A word held in the rounding stage during a stall is not dropped.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !adv) |=> v3_r)
    else $error("pipeline stage lost a word during stall");

endmodule
